[src/scfl_pkg.sv]
// package for the size class free list cache
// shared codes, field widths, state type and width helpers; no dependencies
package scfl_pkg;

  // defaults for the top level parameters
  localparam int NUM_CLASSES_DEF   = 64;
  localparam int MAX_PER_CLASS_DEF = 64;
  localparam int ADDRESS_BITS_DEF  = 48;

  // fixed field widths of the ports
  localparam int MODE_W        = 2;
  localparam int CLASS_FIELD_W = 7;
  localparam int ADDR_FIELD_W  = 48;
  localparam int STATUS_W      = 2;
  localparam int COUNT_W       = 64;
  localparam int TOTAL_FIELD_W = 13;
  localparam int BYTES_FIELD_W = 19;

  // one cached block stands for 64 bytes
  localparam int BLOCK_SHIFT = 6;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_DEALLOC = 2'd1,
    MODE_FLUSH   = 2'd2,
    MODE_STATS   = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_INVALID = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILL,
    S_POP,
    S_FLUSH
  } state_t;

  // index width for n entries, at least one bit
  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

[src/scfl_ram.sv]
// generic single write port, single read port synchronous ram
// registered read data; no dependencies
module scfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/scfl_fill.sv]
// per class fill counts: a small ram plus one valid flag per class
// an entry never written reads as zero; depends on scfl_pkg and scfl_ram
module scfl_fill #(
  parameter  int NUM_CLASSES   = scfl_pkg::NUM_CLASSES_DEF,
  parameter  int MAX_PER_CLASS = scfl_pkg::MAX_PER_CLASS_DEF,
  localparam int CLS_W  = scfl_pkg::idx_w(NUM_CLASSES),
  localparam int FILL_W = $clog2(MAX_PER_CLASS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [CLS_W-1:0]  rd_idx,
  output logic [FILL_W-1:0] rd_fill,
  input  logic              wr_en,
  input  logic [CLS_W-1:0]  wr_idx,
  input  logic [FILL_W-1:0] wr_fill
);

  import scfl_pkg::*;

  logic [NUM_CLASSES-1:0] vld_r;
  logic                   rd_vld_r;
  logic [FILL_W-1:0]      ram_rdata;

  scfl_ram #(
    .WIDTH (FILL_W),
    .DEPTH (NUM_CLASSES),
    .AW    (CLS_W)
  ) u_fill_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata (wr_fill),
    .re    (rd_en),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // valid flags, cleared by reset, set on first write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_idx] <= 1'b1;
    end
  end

  // flag read alongside the ram
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else if (rd_en) begin
      rd_vld_r <= vld_r[rd_idx];
    end
  end

  assign rd_fill = rd_vld_r ? ram_rdata : '0;

endmodule

[src/scfl_ctrl.sv]
// sequencer of the free list cache: decodes a request, does the read,
// modify and write of the fill count and stack, keeps counters and the
// result register; depends on scfl_pkg
module scfl_ctrl #(
  parameter  int NUM_CLASSES   = scfl_pkg::NUM_CLASSES_DEF,
  parameter  int MAX_PER_CLASS = scfl_pkg::MAX_PER_CLASS_DEF,
  parameter  int ADDRESS_BITS  = scfl_pkg::ADDRESS_BITS_DEF,
  localparam int CLS_W   = scfl_pkg::idx_w(NUM_CLASSES),
  localparam int SLOT_W  = scfl_pkg::idx_w(MAX_PER_CLASS),
  localparam int FILL_W  = $clog2(MAX_PER_CLASS + 1),
  localparam int STORE_W = (ADDRESS_BITS < scfl_pkg::ADDR_FIELD_W) ?
                           ADDRESS_BITS : scfl_pkg::ADDR_FIELD_W,
  localparam int STK_AW  = CLS_W + SLOT_W
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request side
  input  logic                                start,
  output logic                                busy,
  input  logic [scfl_pkg::MODE_W-1:0]         in_mode,
  input  logic [scfl_pkg::CLASS_FIELD_W-1:0]  in_size_class,
  input  logic [scfl_pkg::ADDR_FIELD_W-1:0]   in_block_address,
  // fill count table
  output logic                                fill_rd_en,
  output logic [CLS_W-1:0]                    fill_rd_idx,
  input  logic [FILL_W-1:0]                   fill_rd_data,
  output logic                                fill_wr_en,
  output logic [CLS_W-1:0]                    fill_wr_idx,
  output logic [FILL_W-1:0]                   fill_wr_data,
  // stack ram
  output logic                                stk_we,
  output logic [STK_AW-1:0]                   stk_waddr,
  output logic [STORE_W-1:0]                  stk_wdata,
  output logic                                stk_re,
  output logic [STK_AW-1:0]                   stk_raddr,
  input  logic [STORE_W-1:0]                  stk_rdata,
  // result side
  output logic                                out_valid,
  output logic [scfl_pkg::ADDR_FIELD_W-1:0]   out_address,
  output logic [scfl_pkg::STATUS_W-1:0]       out_status,
  output logic                                out_last_of_run,
  output logic [scfl_pkg::COUNT_W-1:0]        out_hit_count,
  output logic [scfl_pkg::COUNT_W-1:0]        out_miss_count,
  output logic [scfl_pkg::TOTAL_FIELD_W-1:0]  out_cached_total,
  output logic [scfl_pkg::BYTES_FIELD_W-1:0]  out_cached_bytes
);

  import scfl_pkg::*;

  localparam int TOT_W = $clog2(NUM_CLASSES * MAX_PER_CLASS + 1);

  state_t             state_r, state_nxt;
  mode_t              mode_r;
  logic [CLS_W-1:0]   cls_r;
  logic               cls_ok_r;
  logic [STORE_W-1:0] addr_r;
  logic [SLOT_W-1:0]  idx_r, idx_nxt;
  logic [COUNT_W-1:0] hit_r, hit_nxt;
  logic [COUNT_W-1:0] miss_r, miss_nxt;
  logic [TOT_W-1:0]   total_r, total_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [ADDR_FIELD_W-1:0] out_addr_r, out_addr_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_stats_r, out_stats_nxt;

  logic              accept;
  logic              in_cls_ok;
  logic              fill_empty;
  logic              fill_full;
  logic              addr_null;
  logic [SLOT_W-1:0] slot_top;
  logic [31:0]       tot32;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign in_cls_ok = ({1'b0, in_size_class} < 8'(NUM_CLASSES));

  // fill table is read as the request is taken
  assign fill_rd_en  = accept;
  assign fill_rd_idx = in_size_class[CLS_W-1:0];

  // decode of the fetched fill count
  assign fill_empty = (fill_rd_data == '0);
  assign fill_full  = (fill_rd_data >= FILL_W'(MAX_PER_CLASS));
  assign addr_null  = (addr_r == '0);
  assign slot_top   = SLOT_W'(fill_rd_data - FILL_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        state_nxt = S_IDLE;
        if (cls_ok_r && !fill_empty) begin
          if (mode_r == MODE_ALLOC) begin
            state_nxt = S_POP;
          end else if (mode_r == MODE_FLUSH) begin
            state_nxt = S_FLUSH;
          end
        end
      end
      S_POP: begin
        state_nxt = S_IDLE;
      end
      S_FLUSH: begin
        if (idx_r == '0) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // memory controls, counters and result word
  always_comb begin
    fill_wr_en     = 1'b0;
    fill_wr_idx    = cls_r;
    fill_wr_data   = '0;
    stk_we         = 1'b0;
    stk_waddr      = {cls_r, SLOT_W'(fill_rd_data)};
    stk_wdata      = addr_r;
    stk_re         = 1'b0;
    stk_raddr      = {cls_r, slot_top};
    idx_nxt        = idx_r;
    hit_nxt        = hit_r;
    miss_nxt       = miss_r;
    total_nxt      = total_r;
    out_valid_nxt  = 1'b0;
    out_addr_nxt   = '0;
    out_status_nxt = STAT_OK;
    out_last_nxt   = 1'b1;
    out_stats_nxt  = 1'b0;
    case (state_r)
      S_FILL: begin
        case (mode_r)
          MODE_ALLOC: begin
            if (!cls_ok_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_INVALID;
            end else if (fill_empty) begin
              miss_nxt       = miss_r + COUNT_W'(1);
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_EMPTY;
            end else begin
              // pop: lower the fill count, fetch the top entry
              fill_wr_en   = 1'b1;
              fill_wr_data = fill_rd_data - FILL_W'(1);
              stk_re       = 1'b1;
            end
          end
          MODE_DEALLOC: begin
            if (!cls_ok_r || addr_null) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_INVALID;
            end else if (fill_full) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_FULL;
            end else begin
              // push at the current fill position
              stk_we         = 1'b1;
              fill_wr_en     = 1'b1;
              fill_wr_data   = fill_rd_data + FILL_W'(1);
              total_nxt      = total_r + TOT_W'(1);
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_OK;
            end
          end
          MODE_FLUSH: begin
            if (!cls_ok_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_INVALID;
            end else if (fill_empty) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_EMPTY;
            end else begin
              // empty the class and start the walk at the top entry
              fill_wr_en   = 1'b1;
              fill_wr_data = '0;
              total_nxt    = total_r - TOT_W'(fill_rd_data);
              stk_re       = 1'b1;
              idx_nxt      = slot_top;
            end
          end
          MODE_STATS: begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = STAT_OK;
            out_stats_nxt  = 1'b1;
          end
          default: begin
            out_valid_nxt = 1'b0;
          end
        endcase
      end
      S_POP: begin
        hit_nxt        = hit_r + COUNT_W'(1);
        total_nxt      = total_r - TOT_W'(1);
        out_valid_nxt  = 1'b1;
        out_addr_nxt   = ADDR_FIELD_W'(stk_rdata);
        out_status_nxt = STAT_OK;
      end
      S_FLUSH: begin
        // emit the fetched entry, fetch the next one down
        out_valid_nxt  = 1'b1;
        out_addr_nxt   = ADDR_FIELD_W'(stk_rdata);
        out_status_nxt = STAT_OK;
        out_last_nxt   = (idx_r == '0);
        if (idx_r != '0) begin
          idx_nxt   = idx_r - SLOT_W'(1);
          stk_re    = 1'b1;
          stk_raddr = {cls_r, idx_r - SLOT_W'(1)};
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hit_r       <= '0;
      miss_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hit_r       <= hit_nxt;
      miss_r      <= miss_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // request and result payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r   <= mode_t'(in_mode);
      cls_r    <= in_size_class[CLS_W-1:0];
      cls_ok_r <= in_cls_ok;
      addr_r   <= in_block_address[STORE_W-1:0];
    end
    idx_r        <= idx_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
    out_stats_r  <= out_stats_nxt;
  end

  // result ports; the total holds still while a word is shown
  assign tot32            = 32'(total_r);
  assign out_valid        = out_valid_r;
  assign out_address      = out_addr_r;
  assign out_status       = out_status_r;
  assign out_last_of_run  = out_last_r;
  assign out_hit_count    = out_stats_r ? hit_r : '0;
  assign out_miss_count   = out_stats_r ? miss_r : '0;
  assign out_cached_total = tot32[TOTAL_FIELD_W-1:0];
  assign out_cached_bytes = BYTES_FIELD_W'(tot32 << BLOCK_SHIFT);

endmodule

[src/size_class_free_list_cache_core.sv]
// Per size class free list cache. A request is taken when start is high and
// busy is low; every result word is shown for one cycle with out_valid high
// and cannot be held off, so the receiver must take each word as it comes.
// Statistics, invalid requests, misses, empty flushes and deallocates go
// through a fill count read, then decision and write back; an allocate
// hit adds a stack memory read, and a flush of n entries does one stack
// read per entry.
// No clearing pass is needed after reset.
// top level; depends on scfl_pkg, scfl_ram, scfl_fill and scfl_ctrl
module size_class_free_list_cache_core #(
  parameter int NUM_CLASSES   = scfl_pkg::NUM_CLASSES_DEF,
  parameter int MAX_PER_CLASS = scfl_pkg::MAX_PER_CLASS_DEF,
  parameter int ADDRESS_BITS  = scfl_pkg::ADDRESS_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [scfl_pkg::MODE_W-1:0]         in_mode,
  input  logic [scfl_pkg::CLASS_FIELD_W-1:0]  in_size_class,
  input  logic [scfl_pkg::ADDR_FIELD_W-1:0]   in_block_address,
  output logic                                out_valid,
  output logic [scfl_pkg::ADDR_FIELD_W-1:0]   out_address,
  output logic [scfl_pkg::STATUS_W-1:0]       out_status,
  output logic                                out_last_of_run,
  output logic [scfl_pkg::COUNT_W-1:0]        out_hit_count,
  output logic [scfl_pkg::COUNT_W-1:0]        out_miss_count,
  output logic [scfl_pkg::TOTAL_FIELD_W-1:0]  out_cached_total,
  output logic [scfl_pkg::BYTES_FIELD_W-1:0]  out_cached_bytes
);

  import scfl_pkg::*;

  localparam int CLS_W   = idx_w(NUM_CLASSES);
  localparam int SLOT_W  = idx_w(MAX_PER_CLASS);
  localparam int FILL_W  = $clog2(MAX_PER_CLASS + 1);
  localparam int STORE_W = (ADDRESS_BITS < ADDR_FIELD_W) ? ADDRESS_BITS : ADDR_FIELD_W;
  localparam int STK_AW  = CLS_W + SLOT_W;

  logic              fill_rd_en;
  logic [CLS_W-1:0]  fill_rd_idx;
  logic [FILL_W-1:0] fill_rd_data;
  logic              fill_wr_en;
  logic [CLS_W-1:0]  fill_wr_idx;
  logic [FILL_W-1:0] fill_wr_data;

  logic               stk_we;
  logic [STK_AW-1:0]  stk_waddr;
  logic [STORE_W-1:0] stk_wdata;
  logic               stk_re;
  logic [STK_AW-1:0]  stk_raddr;
  logic [STORE_W-1:0] stk_rdata;

  // fill counts per class
  scfl_fill #(
    .NUM_CLASSES   (NUM_CLASSES),
    .MAX_PER_CLASS (MAX_PER_CLASS)
  ) u_fill (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (fill_rd_en),
    .rd_idx  (fill_rd_idx),
    .rd_fill (fill_rd_data),
    .wr_en   (fill_wr_en),
    .wr_idx  (fill_wr_idx),
    .wr_fill (fill_wr_data)
  );

  // stack entries, one row of slots per class
  scfl_ram #(
    .WIDTH (STORE_W),
    .DEPTH (2 ** STK_AW),
    .AW    (STK_AW)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // request sequencer
  scfl_ctrl #(
    .NUM_CLASSES   (NUM_CLASSES),
    .MAX_PER_CLASS (MAX_PER_CLASS),
    .ADDRESS_BITS  (ADDRESS_BITS)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_size_class    (in_size_class),
    .in_block_address (in_block_address),
    .fill_rd_en       (fill_rd_en),
    .fill_rd_idx      (fill_rd_idx),
    .fill_rd_data     (fill_rd_data),
    .fill_wr_en       (fill_wr_en),
    .fill_wr_idx      (fill_wr_idx),
    .fill_wr_data     (fill_wr_data),
    .stk_we           (stk_we),
    .stk_waddr        (stk_waddr),
    .stk_wdata        (stk_wdata),
    .stk_re           (stk_re),
    .stk_raddr        (stk_raddr),
    .stk_rdata        (stk_rdata),
    .out_valid        (out_valid),
    .out_address      (out_address),
    .out_status       (out_status),
    .out_last_of_run  (out_last_of_run),
    .out_hit_count    (out_hit_count),
    .out_miss_count   (out_miss_count),
    .out_cached_total (out_cached_total),
    .out_cached_bytes (out_cached_bytes)
  );

endmodule

[tb/sv/tb.sv]
// testbench for size_class_free_list_cache_core: directed table, a full class test, then random request streams
// checks every result word against typed expectations or a predictor of the per class stacks; depends on scfl_pkg
`timescale 1ns / 1ps

module tb;
  import scfl_pkg::*;

  localparam int NCLS         = NUM_CLASSES_DEF;
  localparam int DEPTH        = MAX_PER_CLASS_DEF;
  localparam int RANDOM_ITEMS = 250;
  localparam int CYCLE_LIMIT  = 300000;

  // one request word of the directed table; typed rows carry their own expectation
  typedef struct {
    mode_t       mode;
    logic [6:0]  cls;
    logic [47:0] addr;
    bit          typed;
    logic [1:0]  st;
    logic [47:0] xaddr;
    logic [63:0] xhits;
    logic [63:0] xmiss;
    logic [12:0] xtotal;
  } stim_row_t;

  // one result word
  typedef struct {
    logic [47:0] addr;
    logic [1:0]  st;
    logic        last;
    logic [63:0] hits;
    logic [63:0] miss;
    logic [12:0] total;
    logic [18:0] bytes;
  } cache_word_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_mode;
  logic [6:0]  in_size_class;
  logic [47:0] in_block_address;
  logic        out_valid;
  logic [47:0] out_address;
  logic [1:0]  out_status;
  logic        out_last_of_run;
  logic [63:0] out_hit_count;
  logic [63:0] out_miss_count;
  logic [12:0] out_cached_total;
  logic [18:0] out_cached_bytes;

  size_class_free_list_cache_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_size_class    (in_size_class),
    .in_block_address (in_block_address),
    .out_valid        (out_valid),
    .out_address      (out_address),
    .out_status       (out_status),
    .out_last_of_run  (out_last_of_run),
    .out_hit_count    (out_hit_count),
    .out_miss_count   (out_miss_count),
    .out_cached_total (out_cached_total),
    .out_cached_bytes (out_cached_bytes)
  );

  // predicted cache contents
  logic [47:0] held_addr [NCLS][DEPTH];
  int          fill_level [NCLS];
  logic [63:0] hits_seen;
  logic [63:0] misses_seen;
  int          blocks_held;

  cache_word_t model_words[$];
  cache_word_t pending_words[$];

  int error_count;
  int items_sent;
  int words_checked;
  int full_rejects;
  int flush_runs;
  int longest_flush;
  int burst_left;
  int cycles;
  logic [6:0] hot_cls [4];

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words pending", cycles, pending_words.size());
      $display("tb failed");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("mismatch at word %0d: %s", words_checked, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] exp);
    if (got !== exp)
      report($sformatf("%s got %h expected %h", name, got, exp));
  endtask

  function automatic void add_word(input logic [47:0] a, input logic [1:0] st, input bit last,
                                   input logic [63:0] h, input logic [63:0] m);
    cache_word_t w;
    w.addr  = a;
    w.st    = st;
    w.last  = last;
    w.hits  = h;
    w.miss  = m;
    w.total = 13'(blocks_held);
    w.bytes = 19'(blocks_held * 64);
    model_words = {model_words, w};
  endfunction

  // predict the words caused by one accepted request and update the cache state
  function automatic void cache_predict(input mode_t m, input logic [6:0] c, input logic [47:0] a);
    bit   ok_cls;
    int   ci;
    int   n;
    logic [47:0] pop_addr;
    ok_cls = (c < NCLS);
    ci = ok_cls ? int'(c) : 0;
    model_words.delete();
    case (m)
      MODE_ALLOC: begin
        if (!ok_cls) begin
          add_word('0, STAT_INVALID, 1'b1, '0, '0);
        end else if (fill_level[ci] == 0) begin
          misses_seen++;
          add_word('0, STAT_EMPTY, 1'b1, '0, '0);
        end else begin
          fill_level[ci]--;
          pop_addr = held_addr[ci][fill_level[ci]];
          blocks_held--;
          hits_seen++;
          add_word(pop_addr, STAT_OK, 1'b1, '0, '0);
        end
      end
      MODE_DEALLOC: begin
        if (!ok_cls || a == '0) begin
          add_word('0, STAT_INVALID, 1'b1, '0, '0);
        end else if (fill_level[ci] >= DEPTH) begin
          full_rejects++;
          add_word('0, STAT_FULL, 1'b1, '0, '0);
        end else begin
          held_addr[ci][fill_level[ci]] = a;
          fill_level[ci]++;
          blocks_held++;
          add_word('0, STAT_OK, 1'b1, '0, '0);
        end
      end
      MODE_FLUSH: begin
        n = fill_level[ci];
        if (!ok_cls) begin
          add_word('0, STAT_INVALID, 1'b1, '0, '0);
        end else if (n == 0) begin
          add_word('0, STAT_EMPTY, 1'b1, '0, '0);
        end else begin
          fill_level[ci] = 0;
          blocks_held -= n;
          flush_runs++;
          if (n > longest_flush) longest_flush = n;
          for (int i = 0; i < n; i++)
            add_word(held_addr[ci][n-1-i], STAT_OK, (i == n - 1), '0, '0);
        end
      end
      default: begin
        add_word('0, STAT_OK, 1'b1, hits_seen, misses_seen);
      end
    endcase
  endfunction

  // drive one word at the falling edge and hold it until taken
  task automatic issue(input stim_row_t r);
    cache_word_t w;
    @(negedge clk);
    start            <= 1'b1;
    in_mode          <= r.mode;
    in_size_class    <= r.cls;
    in_block_address <= r.addr;
    do @(posedge clk); while (busy);
    items_sent++;
    cache_predict(r.mode, r.cls, r.addr);
    if (r.typed) begin
      w.addr  = r.xaddr;
      w.st    = r.st;
      w.last  = 1'b1;
      w.hits  = r.xhits;
      w.miss  = r.xmiss;
      w.total = r.xtotal;
      w.bytes = 19'(r.xtotal) << 6;
      pending_words = {pending_words, w};
    end else begin
      pending_words = {pending_words, model_words};
    end
  endtask

  task automatic send(input mode_t m, input logic [6:0] c, input logic [47:0] a);
    stim_row_t r;
    r = '{mode: m, cls: c, addr: a, typed: 1'b0, st: '0, xaddr: '0,
          xhits: '0, xmiss: '0, xtotal: '0};
    issue(r);
  endtask

  // start low, with junk on the idle fields
  task automatic idle(input int n);
    repeat (n) begin
      @(negedge clk);
      start            <= 1'b0;
      in_mode          <= 2'($urandom);
      in_size_class    <= 7'($urandom);
      in_block_address <= {16'($urandom), 32'($urandom)};
    end
  endtask

  // sender bursts with random gaps, some long bursts with none
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      idle($urandom_range(1, 6));
      burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 8);
    end
  endtask

  task automatic drain();
    idle(1);
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  function automatic logic [47:0] rand_addr();
    logic [47:0] a;
    a = {16'($urandom), 32'($urandom)};
    case ($urandom_range(0, 19))
      0:       a = '1;
      1:       a = 48'd1;
      default: if (a == '0) a = 48'd1;
    endcase
    return a;
  endfunction

  // mostly hot classes so stacks get deep, some cold, a few invalid
  function automatic logic [6:0] pick_class();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return hot_cls[$urandom_range(0, 3)];
    if (r < 90) return 7'($urandom_range(0, NCLS - 1));
    return 7'($urandom_range(NCLS, 127));
  endfunction

  // result checker
  always @(posedge clk) begin : result_check
    cache_word_t w;
    if (rst_n && out_valid) begin
      if (pending_words.size() == 0) begin
        report("result word with nothing pending");
      end else begin
        w = pending_words.pop_front();
        check_field("address", out_address, w.addr);
        check_field("status", out_status, w.st);
        check_field("last", out_last_of_run, w.last);
        check_field("hit count", out_hit_count, w.hits);
        check_field("miss count", out_miss_count, w.miss);
        check_field("cached total", out_cached_total, w.total);
        check_field("cached bytes", out_cached_bytes, w.bytes);
      end
      words_checked++;
    end
  end

  // directed table: rows with typed expectations first, predictor rows after
  stim_row_t directed [] = '{
    '{MODE_STATS,   7'd0,   48'h0,            1, STAT_OK,      48'h0, 64'd0, 64'd0, 13'd0},
    '{MODE_ALLOC,   7'd5,   48'h0,            1, STAT_EMPTY,   48'h0, 64'd0, 64'd0, 13'd0},
    '{MODE_ALLOC,   7'd64,  48'h0,            1, STAT_INVALID, 48'h0, 64'd0, 64'd0, 13'd0},
    '{MODE_ALLOC,   7'd127, 48'h0,            1, STAT_INVALID, 48'h0, 64'd0, 64'd0, 13'd0},
    '{MODE_DEALLOC, 7'd0,   48'h0,            1, STAT_INVALID, 48'h0, 64'd0, 64'd0, 13'd0},
    '{MODE_DEALLOC, 7'd127, 48'hFFFFFFFFFFFF, 1, STAT_INVALID, 48'h0, 64'd0, 64'd0, 13'd0},
    '{MODE_DEALLOC, 7'd64,  48'h1,            1, STAT_INVALID, 48'h0, 64'd0, 64'd0, 13'd0},
    '{MODE_FLUSH,   7'd64,  48'h0,            1, STAT_INVALID, 48'h0, 64'd0, 64'd0, 13'd0},
    '{MODE_FLUSH,   7'd127, 48'h0,            1, STAT_INVALID, 48'h0, 64'd0, 64'd0, 13'd0},
    '{MODE_FLUSH,   7'd3,   48'h0,            1, STAT_EMPTY,   48'h0, 64'd0, 64'd0, 13'd0},
    '{MODE_STATS,   7'd127, 48'h123,          1, STAT_OK,      48'h0, 64'd0, 64'd1, 13'd0},
    '{MODE_DEALLOC, 7'd0,   48'hFFFFFFFFFFFF, 1, STAT_OK,      48'h0, 64'd0, 64'd0, 13'd1},
    '{MODE_DEALLOC, 7'd63,  48'h1,            1, STAT_OK,      48'h0, 64'd0, 64'd0, 13'd2},
    '{MODE_DEALLOC, 7'd63,  48'hAAAA5555AAAA, 0, STAT_OK,      48'h0, 64'd0, 64'd0, 13'd0},
    '{MODE_DEALLOC, 7'd63,  48'h5555AAAA5555, 0, STAT_OK,      48'h0, 64'd0, 64'd0, 13'd0},
    '{MODE_ALLOC,   7'd63,  48'hFFFFFFFFFFFF, 0, STAT_OK,      48'h0, 64'd0, 64'd0, 13'd0},
    '{MODE_ALLOC,   7'd0,   48'h0,            0, STAT_OK,      48'h0, 64'd0, 64'd0, 13'd0},
    '{MODE_ALLOC,   7'd0,   48'h0,            0, STAT_OK,      48'h0, 64'd0, 64'd0, 13'd0},
    '{MODE_STATS,   7'd64,  48'h0,            0, STAT_OK,      48'h0, 64'd0, 64'd0, 13'd0},
    '{MODE_FLUSH,   7'd63,  48'h0,            0, STAT_OK,      48'h0, 64'd0, 64'd0, 13'd0},
    '{MODE_DEALLOC, 7'd1,   48'h800000000000, 0, STAT_OK,      48'h0, 64'd0, 64'd0, 13'd0},
    '{MODE_DEALLOC, 7'd1,   48'h7FFFFFFFFFFF, 0, STAT_OK,      48'h0, 64'd0, 64'd0, 13'd0},
    '{MODE_FLUSH,   7'd1,   48'hFFFFFFFFFFFF, 0, STAT_OK,      48'h0, 64'd0, 64'd0, 13'd0},
    '{MODE_STATS,   7'd0,   48'h0,            0, STAT_OK,      48'h0, 64'd0, 64'd0, 13'd0}
  };

  // stimulus
  initial begin : stimulus
    int          kind;
    int          n;
    int          stop_at;
    bit          paused;
    logic [6:0]  c;

    start            = 1'b0;
    in_mode          = '0;
    in_size_class    = '0;
    in_block_address = '0;
    rst_n            = 1'b0;
    foreach (fill_level[i]) fill_level[i] = 0;
    hits_seen     = '0;
    misses_seen   = '0;
    blocks_held   = 0;
    error_count   = 0;
    items_sent    = 0;
    words_checked = 0;
    full_rejects  = 0;
    flush_runs    = 0;
    longest_flush = 0;
    burst_left    = 0;
    paused        = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part
    foreach (directed[i]) begin
      issue(directed[i]);
      pace();
    end
    drain();

    // fill one class to the limit, push past it, pop and push once, read the stats, then flush the whole stack
    c = 7'($urandom_range(0, NCLS - 1));
    while (fill_level[c] < DEPTH) begin
      send(MODE_DEALLOC, c, rand_addr());
      pace();
    end
    send(MODE_DEALLOC, c, rand_addr());
    send(MODE_DEALLOC, c, rand_addr());
    send(MODE_ALLOC, c, '0);
    send(MODE_DEALLOC, c, rand_addr());
    send(MODE_STATS, c, '0);
    send(MODE_FLUSH, c, '0);
    drain();

    // random streams of well-formed pushes and pops, with some noise
    hot_cls[0] = 7'd0;
    hot_cls[1] = 7'(NCLS - 1);
    hot_cls[2] = 7'($urandom_range(1, NCLS - 2));
    hot_cls[3] = 7'($urandom_range(1, NCLS - 2));
    stop_at = directed.size() + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      c = pick_class();
      if (kind < 35) begin
        n = $urandom_range(1, 10);
        repeat (n) begin
          send(MODE_DEALLOC, c, rand_addr());
          pace();
        end
      end else if (kind < 58) begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          send(MODE_ALLOC, c, rand_addr());
          pace();
        end
      end else if (kind < 68) begin
        send(MODE_FLUSH, c, rand_addr());
        pace();
      end else if (kind < 76) begin
        send(MODE_STATS, 7'($urandom), rand_addr());
        pace();
      end else if (kind < 88) begin
        send(mode_t'($urandom_range(0, 3)), 7'($urandom),
             ($urandom_range(0, 3) == 0) ? 48'h0 : {16'($urandom), 32'($urandom)});
        pace();
      end else begin
        n = $urandom_range(4, 12);
        repeat (n) begin
          send(($urandom_range(0, 2) == 0) ? MODE_ALLOC : MODE_DEALLOC, c, rand_addr());
          pace();
        end
      end
      // hold the sender once until everything pending has come out
      if (!paused && items_sent > stop_at - RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        drain();
      end
    end

    // empty every hot class so long flushes close the run
    foreach (hot_cls[i]) begin
      send(MODE_FLUSH, hot_cls[i], '0);
      pace();
    end
    send(MODE_STATS, '0, '0);
    drain();
    repeat (20) @(posedge clk);
    if (pending_words.size() != 0)
      report($sformatf("%0d words never arrived", pending_words.size()));

    $display("run: %0d request words, %0d result words, %0d hits, %0d misses",
             items_sent, words_checked, hits_seen, misses_seen);
    $display("     %0d full rejects, %0d flushes, longest flush %0d words, %0d mismatches",
             full_rejects, flush_runs, longest_flush, error_count);
    if (error_count == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
